// ----- rtl/jrds_pkg.sv -----
// Package for the joystick RGB duty setter: configuration register codes,
// configuration and result types, slider position helper.
// No dependencies.
package jrds_pkg;

  // Field widths fixed by the register map and the result format
  localparam int THR_W   = 10;
  localparam int STEP_W  = 8;
  localparam int LEVEL_W = 8;
  localparam int CHAN_W  = 2;
  localparam int SLIDE_W = 6;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 10;

  // Reset values of the configuration registers
  localparam logic [THR_W-1:0]  UP_SLOW_RST   = 10'd600;
  localparam logic [THR_W-1:0]  UP_FAST_RST   = 10'd900;
  localparam logic [THR_W-1:0]  DN_SLOW_RST   = 10'd400;
  localparam logic [THR_W-1:0]  DN_FAST_RST   = 10'd100;
  localparam logic [THR_W-1:0]  SEL_HIGH_RST  = 10'd680;
  localparam logic [THR_W-1:0]  SEL_LOW_RST   = 10'd340;
  localparam logic [STEP_W-1:0] FINE_RST      = 8'd1;
  localparam logic [STEP_W-1:0] COARSE_RST    = 8'd10;

  // Level limits and slider offset
  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 8'd255;
  localparam logic [SLIDE_W-1:0] SLIDE_OFFSET = 6'd9;
  // x / 5 == (x * 205) >> 10 for every 8-bit x
  localparam logic [17:0]        DIV5_MUL     = 18'd205;

  // Channel codes
  localparam logic [CHAN_W-1:0] CH_NONE  = 2'd0;
  localparam logic [CHAN_W-1:0] CH_RED   = 2'd1;
  localparam logic [CHAN_W-1:0] CH_GREEN = 2'd2;
  localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd3;
  localparam logic [CHAN_W-1:0] CH_ONE   = 2'd1;

  // Configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_UP_SLOW  = 3'd0,
    CFG_UP_FAST  = 3'd1,
    CFG_DN_SLOW  = 3'd2,
    CFG_DN_FAST  = 3'd3,
    CFG_SEL_HIGH = 3'd4,
    CFG_SEL_LOW  = 3'd5,
    CFG_FINE     = 3'd6,
    CFG_COARSE   = 3'd7
  } cfg_idx_t;

  // Current configuration, as seen by the control stage
  typedef struct packed {
    logic [THR_W-1:0]  up_slow;
    logic [THR_W-1:0]  up_fast;
    logic [THR_W-1:0]  dn_slow;
    logic [THR_W-1:0]  dn_fast;
    logic [THR_W-1:0]  sel_high;
    logic [THR_W-1:0]  sel_low;
    logic [STEP_W-1:0] fine;
    logic [STEP_W-1:0] coarse;
  } cfg_t;

  // Result item; last member sits in the lowest bits
  typedef struct packed {
    logic [SLIDE_W-1:0] slider_position;
    logic [LEVEL_W-1:0] blue_duty;
    logic [LEVEL_W-1:0] green_duty;
    logic [LEVEL_W-1:0] red_duty;
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;
  } res_t;

  // Slider column: 9 + level / 5
  function automatic logic [SLIDE_W-1:0] slider_of(input logic [LEVEL_W-1:0] lvl);
    logic [17:0] prod;
    prod = {10'b0, lvl} * DIV5_MUL;
    return SLIDE_OFFSET + prod[15:10];
  endfunction

endpackage

// ----- rtl/joystick_rgb_duty_setter_core.sv -----
// Top level of the joystick RGB duty setter: stream ports, config port.
// Depends on jrds_pkg, jrds_cfg_regs, jrds_win_acc, jrds_ctrl.
//
//   port group   dir  contents
//   s_axis_*     in   sample pairs (level_sample, select_sample)
//   m_axis_*     out  level, channel, red/green/blue duty, slider position
//   cfg_*        in   register writes, index 0..7, no read-back
//
// One item is accepted per cycle while results are being taken; a result
// passes from the edge that takes the last item of its window into the
// average register, then into the result register. A window is
// 2^WINDOW_LOG2 items and gives at most one result. rst clears sums, count,
// level, channel, holds and duties and loads the register defaults. A stalled
// output holds its item; input keeps being taken until a finished window
// average is waiting behind it.
module joystick_rgb_duty_setter_core
  import jrds_pkg::*;
#(
  parameter int WINDOW_LOG2 = 6,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  // tdata: level_sample, select_sample, zero fill
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: level, channel, red_duty, green_duty, blue_duty, slider_position
  output logic [$bits(res_t)-1:0] m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_we,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [CFG_D_W-1:0]    cfg_wdata
);

  cfg_t                   cfg;
  logic                   in_take;
  logic                   win_valid;
  logic                   win_take;
  logic [SAMPLE_BITS-1:0] level_avg;
  logic [SAMPLE_BITS-1:0] select_avg;
  res_t                   res;

  // Input is taken unless a window average is stuck waiting
  assign s_axis_tready = !win_valid || win_take;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = res;

  jrds_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  jrds_win_acc #(
    .WINDOW_LOG2 (WINDOW_LOG2),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_acc (
    .clk           (clk),
    .rst           (rst),
    .in_take       (in_take),
    .level_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .select_sample (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .win_take      (win_take),
    .win_valid     (win_valid),
    .level_avg     (level_avg),
    .select_avg    (select_avg)
  );

  jrds_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .win_valid  (win_valid),
    .level_avg  (level_avg),
    .select_avg (select_avg),
    .win_take   (win_take),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

endmodule

// ----- rtl/jrds_cfg_regs.sv -----
// Configuration register file of the duty setter.
// Depends on jrds_pkg.
module jrds_cfg_regs
  import jrds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata,
  output cfg_t               cfg
);

  // Write decode, one register per index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.up_slow  <= UP_SLOW_RST;
      cfg.up_fast  <= UP_FAST_RST;
      cfg.dn_slow  <= DN_SLOW_RST;
      cfg.dn_fast  <= DN_FAST_RST;
      cfg.sel_high <= SEL_HIGH_RST;
      cfg.sel_low  <= SEL_LOW_RST;
      cfg.fine     <= FINE_RST;
      cfg.coarse   <= COARSE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_UP_SLOW:  cfg.up_slow  <= cfg_wdata[THR_W-1:0];
        CFG_UP_FAST:  cfg.up_fast  <= cfg_wdata[THR_W-1:0];
        CFG_DN_SLOW:  cfg.dn_slow  <= cfg_wdata[THR_W-1:0];
        CFG_DN_FAST:  cfg.dn_fast  <= cfg_wdata[THR_W-1:0];
        CFG_SEL_HIGH: cfg.sel_high <= cfg_wdata[THR_W-1:0];
        CFG_SEL_LOW:  cfg.sel_low  <= cfg_wdata[THR_W-1:0];
        CFG_FINE:     cfg.fine     <= cfg_wdata[STEP_W-1:0];
        CFG_COARSE:   cfg.coarse   <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/jrds_win_acc.sv -----
// Window accumulator: sums sample pairs and registers the window averages.
// Depends on jrds_pkg.
module jrds_win_acc
  import jrds_pkg::*;
#(
  parameter int WINDOW_LOG2 = 6,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_take,
  input  logic [SAMPLE_BITS-1:0] level_sample,
  input  logic [SAMPLE_BITS-1:0] select_sample,
  input  logic                   win_take,
  output logic                   win_valid,
  output logic [SAMPLE_BITS-1:0] level_avg,
  output logic [SAMPLE_BITS-1:0] select_avg
);

  localparam int SUM_W = SAMPLE_BITS + WINDOW_LOG2;
  localparam int CNT_W = (WINDOW_LOG2 > 0) ? WINDOW_LOG2 : 1;
  localparam int WIN_LEN = 1 << WINDOW_LOG2;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIN_LEN - 1);

  logic [SUM_W-1:0] level_sum, level_sum_next;
  logic [SUM_W-1:0] select_sum, select_sum_next;
  logic [CNT_W-1:0] sample_count;
  logic             win_end;

  // Running sums including the item on offer
  assign level_sum_next  = level_sum + SUM_W'(level_sample);
  assign select_sum_next = select_sum + SUM_W'(select_sample);
  assign win_end         = (sample_count == CNT_LAST);

  // Accumulate; clear at window end
  always_ff @(posedge clk) begin
    if (rst) begin
      level_sum    <= '0;
      select_sum   <= '0;
      sample_count <= '0;
    end else if (in_take) begin
      if (win_end) begin
        level_sum    <= '0;
        select_sum   <= '0;
        sample_count <= '0;
      end else begin
        level_sum    <= level_sum_next;
        select_sum   <= select_sum_next;
        sample_count <= sample_count + CNT_W'(1);
      end
    end
  end

  // Average register handed to the control stage
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (in_take && win_end) begin
      win_valid <= 1'b1;
    end else if (win_take) begin
      win_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && win_end) begin
      level_avg  <= level_sum_next[SUM_W-1:WINDOW_LOG2];
      select_avg <= select_sum_next[SUM_W-1:WINDOW_LOG2];
    end
  end

endmodule

// ----- rtl/jrds_ctrl.sv -----
// Control stage: level step, select press tracking, duty latch, result register.
// Depends on jrds_pkg.
module jrds_ctrl
  import jrds_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   win_valid,
  input  logic [SAMPLE_BITS-1:0] level_avg,
  input  logic [SAMPLE_BITS-1:0] select_avg,
  output logic                   win_take,
  output logic                   res_valid,
  input  logic                   res_ready,
  output res_t                   res
);

  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic [LEVEL_W-1:0] level_value, level_value_next, level_stepped;
  logic [CHAN_W-1:0]  channel_index, channel_index_next;
  logic               hold_next, hold_next_next;
  logic               hold_previous, hold_previous_next;
  logic [LEVEL_W-1:0] red_value, red_value_next;
  logic [LEVEL_W-1:0] green_value, green_value_next;
  logic [LEVEL_W-1:0] blue_value, blue_value_next;
  logic               emit;

  logic [CMP_W-1:0]   lavg, savg;
  logic               sel_hi, sel_lo;
  logic [STEP_W-1:0]  up_amt, dn_amt;
  logic signed [9:0]  v;

  // Result register is free when empty or being taken
  assign win_take = win_valid && (!res_valid || res_ready);

  assign lavg   = CMP_W'(level_avg);
  assign savg   = CMP_W'(select_avg);
  assign sel_hi = (savg >= CMP_W'(cfg.sel_high));
  assign sel_lo = (savg <= CMP_W'(cfg.sel_low));

  // Level step: both bands may apply, net change saturated to 0..255
  always_comb begin
    up_amt = '0;
    dn_amt = '0;
    if (lavg >= CMP_W'(cfg.up_slow)) begin
      up_amt = (lavg > CMP_W'(cfg.up_fast)) ? cfg.coarse : cfg.fine;
    end
    if (lavg <= CMP_W'(cfg.dn_slow)) begin
      dn_amt = (lavg < CMP_W'(cfg.dn_fast)) ? cfg.coarse : cfg.fine;
    end
    v = $signed({2'b00, level_value}) + $signed({2'b00, up_amt})
        - $signed({2'b00, dn_amt});
    if (v < 0) begin
      level_stepped = '0;
    end else if (v[8]) begin
      level_stepped = LEVEL_MAX;
    end else begin
      level_stepped = v[7:0];
    end
  end

  // Window-end decision
  always_comb begin
    level_value_next   = level_value;
    channel_index_next = channel_index;
    hold_next_next     = hold_next;
    hold_previous_next = hold_previous;
    red_value_next     = red_value;
    green_value_next   = green_value;
    blue_value_next    = blue_value;
    emit               = 1'b0;
    if (win_take) begin
      if (hold_next) begin
        if (!sel_hi) begin
          hold_next_next     = 1'b0;
          channel_index_next = channel_index + CH_ONE;
          emit               = 1'b1;
        end
      end else if (hold_previous) begin
        if (!sel_lo) begin
          hold_previous_next = 1'b0;
          channel_index_next = channel_index - CH_ONE;
          emit               = 1'b1;
        end
      end else begin
        level_value_next = level_stepped;
        if (sel_hi) begin
          hold_next_next = 1'b1;
        end else if (sel_lo) begin
          hold_previous_next = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      // Latch the level into the selected channel's duty
      if (emit) begin
        case (channel_index_next)
          CH_RED:   red_value_next   = level_value_next;
          CH_GREEN: green_value_next = level_value_next;
          CH_BLUE:  blue_value_next  = level_value_next;
          default: ;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level_value   <= '0;
      channel_index <= CH_NONE;
      hold_next     <= 1'b0;
      hold_previous <= 1'b0;
      red_value     <= '0;
      green_value   <= '0;
      blue_value    <= '0;
    end else begin
      level_value   <= level_value_next;
      channel_index <= channel_index_next;
      hold_next     <= hold_next_next;
      hold_previous <= hold_previous_next;
      red_value     <= red_value_next;
      green_value   <= green_value_next;
      blue_value    <= blue_value_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (win_take) begin
      res_valid <= emit;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (win_take && emit) begin
      res.level           <= level_value_next;
      res.channel         <= channel_index_next;
      res.red_duty        <= red_value_next;
      res.green_duty      <= green_value_next;
      res.blue_duty       <= blue_value_next;
      res.slider_position <= slider_of(level_value_next);
    end
  end

`ifndef SYNTH
  // Only one press direction is ever held
  a_one_hold: assert property (@(posedge clk) disable iff (rst)
    !(hold_next && hold_previous))
    else $error("both press holds set");

  // A new result only appears after a window was taken
  a_res_after_take: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(win_take))
    else $error("result without window end");

  // Channel moves only on a window end
  a_chan_on_take: assert property (@(posedge clk) disable iff (rst)
    !$past(win_take) |-> $stable(channel_index))
    else $error("channel changed outside window end");

  // A press still held gives no result
  a_hold_quiet: assert property (@(posedge clk) disable iff (rst)
    win_take && hold_next && sel_hi |=> !res_valid)
    else $error("result while press held");

  // Level never moves while a press is held
  a_level_held: assert property (@(posedge clk) disable iff (rst)
    (hold_next || hold_previous) |=> $stable(level_value))
    else $error("level stepped during held press");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for joystick_rgb_duty_setter_core: windows of sample pairs
// in, duty results out, checked against an in-bench duty/level predictor.
// Depends on jrds_pkg and joystick_rgb_duty_setter_core.
module tb_top;
  import jrds_pkg::*;

  localparam int WIN_LOG2       = 6;
  localparam int SMP_W          = 10;
  localparam int WIN_LEN        = 1 << WIN_LOG2;
  localparam int SMP_MAX        = (1 << SMP_W) - 1;
  localparam int S_W            = ((2 * SMP_W + 7) / 8) * 8;
  localparam int CLK_HALF       = 4;
  localparam int RST_CYCLES     = 6;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RAND_ITEMS     = 1100;
  localparam int RAND_RESULTS   = 40;
  localparam int RAND_WIN_CAP   = 110;
  localparam int CYCLE_LIMIT    = 600000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [S_W-1:0]         s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [$bits(res_t)-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_A_W-1:0]     cfg_addr = '0;
  logic [CFG_D_W-1:0]     cfg_wdata = '0;

  joystick_rgb_duty_setter_core #(
    .WINDOW_LOG2(WIN_LOG2),
    .SAMPLE_BITS(SMP_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Run-wide bookkeeping
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned pairs_taken = 0;
  int unsigned duties_made = 0;
  logic        src_idle = 1'b0;
  logic        sink_idle = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned holds_done = 0;
  int unsigned sink_wait = 0;

  // Predictor state: registers, window sums, level, channel, holds, duties
  cfg_t        regs_now;
  logic [15:0] lvl_acc;
  logic [15:0] sel_acc;
  int unsigned acc_n;
  logic [7:0]  lvl_now;
  logic [1:0]  chan_now;
  logic        next_held;
  logic        prev_held;
  logic [7:0]  duty_r;
  logic [7:0]  duty_g;
  logic [7:0]  duty_b;
  res_t        pending_duties[$];

  function automatic cfg_t default_regs();
    cfg_t c;
    c.up_slow  = UP_SLOW_RST;
    c.up_fast  = UP_FAST_RST;
    c.dn_slow  = DN_SLOW_RST;
    c.dn_fast  = DN_FAST_RST;
    c.sel_high = SEL_HIGH_RST;
    c.sel_low  = SEL_LOW_RST;
    c.fine     = FINE_RST;
    c.coarse   = COARSE_RST;
    return c;
  endfunction

  function automatic cfg_t random_regs();
    cfg_t c;
    c.up_slow  = 10'($urandom_range(0, SMP_MAX));
    c.up_fast  = 10'($urandom_range(0, SMP_MAX));
    c.dn_slow  = 10'($urandom_range(0, SMP_MAX));
    c.dn_fast  = 10'($urandom_range(0, SMP_MAX));
    c.sel_high = 10'($urandom_range(0, SMP_MAX));
    c.sel_low  = 10'($urandom_range(0, SMP_MAX));
    c.fine     = 8'($urandom_range(0, 255));
    c.coarse   = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic reset_shadow();
    regs_now   = default_regs();
    lvl_acc    = '0;
    sel_acc    = '0;
    acc_n      = 0;
    lvl_now    = '0;
    chan_now   = CH_NONE;
    next_held  = 1'b0;
    prev_held  = 1'b0;
    duty_r     = '0;
    duty_g     = '0;
    duty_b     = '0;
  endtask

  // Level after one window step; both bands may apply, net result saturates
  function automatic logic [7:0] stepped_level(input logic [7:0] cur, input logic [9:0] avg,
                                               input cfg_t c);
    int v;
    v = int'(cur);
    if (avg >= c.up_slow) v = v + int'((avg > c.up_fast) ? c.coarse : c.fine);
    if (avg <= c.dn_slow) v = v - int'((avg < c.dn_fast) ? c.coarse : c.fine);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Fold one accepted pair into the window; at a window end work out the duty result
  task automatic accumulate_pair(input logic [9:0] lvl, input logic [9:0] sel);
    logic [9:0] lavg;
    logic [9:0] savg;
    logic       emit;
    res_t       r;
    pairs_taken++;
    lvl_acc = lvl_acc + lvl;
    sel_acc = sel_acc + sel;
    acc_n++;
    if (acc_n < WIN_LEN) return;
    lavg    = 10'(lvl_acc >> WIN_LOG2);
    savg    = 10'(sel_acc >> WIN_LOG2);
    lvl_acc = '0;
    sel_acc = '0;
    acc_n   = 0;
    emit    = 1'b1;
    if (next_held) begin
      if (savg >= regs_now.sel_high) emit = 1'b0;
      else begin
        next_held = 1'b0;
        chan_now  = chan_now + CH_ONE;
      end
    end else if (prev_held) begin
      if (savg <= regs_now.sel_low) emit = 1'b0;
      else begin
        prev_held = 1'b0;
        chan_now  = chan_now - CH_ONE;
      end
    end else begin
      lvl_now = stepped_level(lvl_now, lavg, regs_now);
      // next-channel press wins when both thresholds are met
      if (savg >= regs_now.sel_high) begin
        next_held = 1'b1;
        emit      = 1'b0;
      end else if (savg <= regs_now.sel_low) begin
        prev_held = 1'b1;
        emit      = 1'b0;
      end
    end
    if (!emit) return;
    case (chan_now)
      CH_RED:   duty_r = lvl_now;
      CH_GREEN: duty_g = lvl_now;
      CH_BLUE:  duty_b = lvl_now;
      default: ;
    endcase
    r.level           = lvl_now;
    r.channel         = chan_now;
    r.red_duty        = duty_r;
    r.green_duty      = duty_g;
    r.blue_duty       = duty_b;
    r.slider_position = 6'(9 + lvl_now / 5);
    pending_duties.push_back(r);
    duties_made++;
  endtask

  // Offer one item and wait for it to be taken
  task automatic send_pair(input logic [9:0] lvl, input logic [9:0] sel);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tdata  <= {{(S_W - 2 * SMP_W){1'b0}}, sel, lvl};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    accumulate_pair(lvl, sel);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_pair(10'($urandom_range(0, SMP_MAX)), 10'($urandom_range(0, SMP_MAX)));
  endtask

  // Half-width of symmetric jitter that keeps a window average exact
  function automatic int jitter(input int tgt, input int spr);
    int room;
    if (tgt >= SMP_MAX) return 0;
    room = (tgt < SMP_MAX - 1 - tgt) ? tgt : SMP_MAX - 1 - tgt;
    if (spr < room) room = spr;
    return int'($urandom_range(0, room));
  endfunction

  // One full window whose averages come out at exactly the two targets
  task automatic send_window(input int l_tgt, input int l_spr, input int s_tgt, input int s_spr);
    int l_d;
    int s_d;
    int l_r;
    int s_r;
    int l_val;
    int s_val;
    l_d = 0;
    s_d = 0;
    while (acc_n != 0) send_noise(1);
    l_r = (l_tgt >= SMP_MAX) ? 0 : int'($urandom_range(0, WIN_LEN - 1));
    s_r = (s_tgt >= SMP_MAX) ? 0 : int'($urandom_range(0, WIN_LEN - 1));
    for (int k = 0; k < WIN_LEN; k++) begin
      if (k % 2 == 0) begin
        l_d = jitter(l_tgt, l_spr);
        s_d = jitter(s_tgt, s_spr);
      end
      l_val = l_tgt + ((k % 2 == 1) ? -l_d : l_d) + ((k < l_r) ? 1 : 0);
      s_val = s_tgt + ((k % 2 == 1) ? -s_d : s_d) + ((k < s_r) ? 1 : 0);
      send_pair(10'(l_val), 10'(s_val));
    end
  endtask

  // Stop offering, let every expected item arrive, then let the pipe empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_D_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Write all eight registers; step registers get junk in the unused top bits
  task automatic load_cfg(input cfg_t c);
    write_reg(CFG_UP_SLOW,  c.up_slow);
    write_reg(CFG_UP_FAST,  c.up_fast);
    write_reg(CFG_DN_SLOW,  c.dn_slow);
    write_reg(CFG_DN_FAST,  c.dn_fast);
    write_reg(CFG_SEL_HIGH, c.sel_high);
    write_reg(CFG_SEL_LOW,  c.sel_low);
    write_reg(CFG_FINE,     {2'($urandom_range(0, 3)), c.fine});
    write_reg(CFG_COARSE,   {2'($urandom_range(0, 3)), c.coarse});
    cfg_we   <= 1'b0;
    regs_now = c;
    @(posedge clk);
  endtask

  // Random window targets, biased towards the current thresholds
  function automatic int near_thr(input int thr);
    int v;
    v = thr + int'($urandom_range(0, 2)) - 1;
    if (v < 0) v = 0;
    if (v > SMP_MAX) v = SMP_MAX;
    return v;
  endfunction

  function automatic int pick_level();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return SMP_MAX;
      2: return near_thr(int'(regs_now.up_slow));
      3: return near_thr(int'(regs_now.up_fast));
      4: return near_thr(int'(regs_now.dn_slow));
      5: return near_thr(int'(regs_now.dn_fast));
      default: return int'($urandom_range(0, SMP_MAX));
    endcase
  endfunction

  function automatic int pick_select();
    int lo;
    int hi;
    lo = int'(regs_now.sel_low) + 1;
    hi = int'(regs_now.sel_high) - 1;
    case ($urandom_range(0, 9))
      5: return near_thr(int'(regs_now.sel_high));
      6: return near_thr(int'(regs_now.sel_low));
      7: return 0;
      8: return SMP_MAX;
      9: return int'($urandom_range(0, SMP_MAX));
      default: begin
        // inside both thresholds: releases a held press, or plain step
        if (lo <= hi) return int'($urandom_range(lo, hi));
        return int'($urandom_range(0, SMP_MAX));
      end
    endcase
  endfunction

  function automatic int pick_spread();
    return ($urandom_range(0, 3) == 0) ? SMP_MAX : int'($urandom_range(0, 40));
  endfunction

  // Fine and coarse steps in both directions, threshold edges, saturation at both ends
  task automatic test_level_steps();
    int lvl_seq [12] = '{0, 1023, 901, 900, 600, 599, 401, 400, 100, 99, 50, 0};
    cfg_t c;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    foreach (lvl_seq[k]) send_window(lvl_seq[k], 20, 500, 20);
    settle();
    c = default_regs();
    c.coarse = 8'd255;
    load_cfg(c);
    send_window(1023, 0, 510, 30);
    send_window(1023, 0, 510, 30);
    send_window(0, 0, 510, 30);
    send_window(99, 30, 510, 30);
  endtask

  // Presses, holds, releases, wrap both ways, no latch on channel none
  task automatic test_channel_walk();
    int l_seq [12] = '{1023, 1023, 500, 950, 500, 500, 700, 500, 1023, 500, 500, 500};
    int s_seq [12] = '{340, 0, 341, 680, 1023, 679, 900, 500, 700, 200, 200, 600};
    int l_both [6] = '{500, 800, 500, 500, 900, 500};
    int s_both [6] = '{350, 350, 299, 350, 100, 100};
    cfg_t c;
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    settle();
    load_cfg(default_regs());
    foreach (l_seq[k]) send_window(l_seq[k], 25, s_seq[k], 25);
    settle();
    // overlapping select thresholds: next press wins
    c = default_regs();
    c.sel_high = 10'd300;
    c.sel_low  = 10'd400;
    load_cfg(c);
    foreach (l_both[k]) send_window(l_both[k], 10, s_both[k], 0);
    send_window(500, 10, 401, 0);
  endtask

  // Up and down bands overlap: both steps in one window, net change saturated
  task automatic test_overlap_bands();
    int l_seq [14] = '{500, 750, 750, 750, 750, 750, 750, 750, 701, 250, 250, 299, 1023, 0};
    cfg_t c;
    src_idle  = 1'b1;
    sink_idle = 1'b0;
    settle();
    c.up_slow  = 10'd200;
    c.up_fast  = 10'd700;
    c.dn_slow  = 10'd800;
    c.dn_fast  = 10'd300;
    c.sel_high = 10'd1023;
    c.sel_low  = 10'd0;
    c.fine     = 8'd5;
    c.coarse   = 8'd40;
    load_cfg(c);
    foreach (l_seq[k]) send_window(l_seq[k], 15, 500, 200);
    repeat (7) send_window(250, 15, 500, 200);
  endtask

  // Registers at their extremes, including settings that hold a press for good
  task automatic test_extreme_regs();
    cfg_t c;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    settle();
    c.up_slow  = 10'd0;
    c.up_fast  = 10'd0;
    c.dn_slow  = 10'd0;
    c.dn_fast  = 10'd0;
    c.sel_high = 10'd1023;
    c.sel_low  = 10'd0;
    c.fine     = 8'd0;
    c.coarse   = 8'd0;
    load_cfg(c);
    send_window(0, 0, 500, 500);
    send_window(1023, 0, 500, 500);
    send_window(1, 0, 1023, 0);
    send_window(700, 300, 512, 100);
    send_window(300, 300, 0, 0);
    send_window(300, 300, 1, 0);
    settle();
    c.up_slow  = 10'd1023;
    c.up_fast  = 10'd1023;
    c.dn_slow  = 10'd1023;
    c.dn_fast  = 10'd1023;
    c.fine     = 8'd255;
    c.coarse   = 8'd255;
    load_cfg(c);
    send_window(1023, 0, 500, 500);
    send_window(1022, 0, 500, 500);
    send_window(1023, 0, 500, 500);
    settle();
    // every select average starts a next press that is never released
    c.sel_high = 10'd0;
    load_cfg(c);
    send_window(1023, 0, 0, 0);
    send_window(1023, 0, 1023, 0);
    settle();
    // released now; then every average starts a previous press
    c.sel_high = 10'd1023;
    c.sel_low  = 10'd1023;
    load_cfg(c);
    send_window(1023, 0, 500, 500);
    send_window(1023, 0, 500, 500);
    send_window(1023, 0, 1022, 0);
    settle();
    load_cfg(default_regs());
    send_window(900, 100, 500, 100);
  endtask

  // Receiver holds off for a long stretch while windows keep coming
  task automatic test_backpressure();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    settle();
    load_cfg(default_regs());
    hold_reqs++;
    repeat (6) send_window(int'($urandom_range(0, SMP_MAX)), 300, 500, 100);
    settle();
  endtask

  // Random settings and windows, with broken windows mixed in; quiet tail
  task automatic test_random_windows();
    int unsigned pairs0;
    int unsigned duties0;
    int unsigned wins;
    pairs0    = pairs_taken;
    duties0   = duties_made;
    wins      = 0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    while ((pairs_taken - pairs0 < RAND_ITEMS || duties_made - duties0 < RAND_RESULTS)
           && wins < RAND_WIN_CAP) begin
      if (wins % 8 == 0) begin
        settle();
        load_cfg(($urandom_range(0, 2) == 0) ? default_regs() : random_regs());
      end
      if ($urandom_range(0, 5) == 0) send_noise($urandom_range(1, 40));
      send_window(pick_level(), pick_spread(), pick_select(), pick_spread());
      wins++;
    end
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (4) send_window(pick_level(), pick_spread(), pick_select(), pick_spread());
  endtask

  // Receiver: random short stalls, or a long counted hold-off on request
  always @(posedge clk) begin
    if (sink_wait != 0) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= sink_wait - 1;
    end else if (hold_reqs != holds_done) begin
      holds_done    <= holds_done + 1;
      m_axis_tready <= 1'b0;
      sink_wait     <= LONG_HOLD - 1;
    end else if (sink_idle && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_duties.size() == 0) begin
        $error("unexpected result item: level %0d channel %0d", got.level, got.channel);
        errors++;
      end else begin
        want = pending_duties.pop_front();
        check_field("level", want.level, got.level);
        check_field("channel", 8'(want.channel), 8'(got.channel));
        check_field("red_duty", want.red_duty, got.red_duty);
        check_field("green_duty", want.green_duty, got.green_duty);
        check_field("blue_duty", want.blue_duty, got.blue_duty);
        check_field("slider_position", 8'(want.slider_position), 8'(got.slider_position));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("joystick_rgb_duty_setter_core verification failed");
      $finish;
    end
  end

  initial begin
    reset_shadow();
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_level_steps();
    test_channel_walk();
    test_overlap_bands();
    test_extreme_regs();
    test_backpressure();
    test_random_windows();
    settle();
    if (errors == 0) begin
      $display("joystick_rgb_duty_setter_core verification clean");
    end else begin
      $display("joystick_rgb_duty_setter_core verification failed");
    end
    $finish;
  end

endmodule
